[rtl/mabl_pkg.sv]
// ----------------------------------------------------------------------------
// mabl_pkg
// Shared types, op codes and CRC-8 helper for the alternating bit mailbox link.
// ----------------------------------------------------------------------------
package mabl_pkg;

	typedef enum logic [2:0] {
		OP_OBSERVE = 3'd0,
		OP_SEND    = 3'd1,
		OP_PROBE   = 3'd2,
		OP_POP     = 3'd3,
		OP_START   = 3'd4
	} op_t;

	localparam logic [0:0] REG_NO_HOST = 1'b0;
	localparam logic [0:0] REG_HOST    = 1'b1;
	localparam int unsigned MAX_PAYLOAD = 6;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] mailbox_word;
		logic [47:0] payload;
		logic [2:0]  payload_len;
	} item_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] b);
		logic [7:0] c;
		c = c_in ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [7:0] crc8_bytes(input logic [63:0] b, input logic [3:0] n);
		logic [7:0] c;
		c = 8'hff;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < n) begin
				c = crc8_byte(c, b[8*i +: 8]);
			end
		end
		return c;
	endfunction

endpackage

[rtl/mailbox_alternating_bit_link_top.sv]
// ----------------------------------------------------------------------------
// mailbox_alternating_bit_link_top
// Target side of a stop-and-wait mailbox link with alternating bit and CRC-8.
// ----------------------------------------------------------------------------
// For each word the link engine first reads the receive ring head, then checks
// the answer, builds or reposts the frame and updates state.
// An answer that stores two bytes adds a second ring write before the next word.
// A two entry input queue and the result register let both sides stall apart.
module mailbox_alternating_bit_link_top #(
	parameter int RX_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [31:0] mailbox_word,
	input  logic [47:0] payload,
	input  logic [2:0]  payload_len,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        post_first,
	output logic [31:0] first_word,
	output logic        post_second,
	output logic [31:0] second_word,
	output logic        send_taken,
	output logic [7:0]  rx_byte,
	output logic        rx_valid,
	output logic [4:0]  rx_count,
	output logic        frame_pending,
	output logic        timed_out,
	output logic        host_seen
);
	import mabl_pkg::*;

	logic [31:0] polls_no_host_q, polls_host_q;
	item_t in_item, q_item;
	logic q_valid, q_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polls_no_host_q <= 32'd6000;
			polls_host_q    <= 32'd60000;
		end else if (cfg_we) begin
			if (cfg_index == REG_NO_HOST) polls_no_host_q <= cfg_data;
			else polls_host_q <= cfg_data;
		end
	end

	assign in_item = '{op: op, mailbox_word: mailbox_word, payload: payload,
		payload_len: payload_len};

	mabl_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
	);

	mabl_back #(.RX_DEPTH(RX_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item),
		.q_take(q_take), .polls_no_host(polls_no_host_q), .polls_host(polls_host_q),
		.out_valid(out_valid), .out_stall(out_stall),
		.post_first(post_first), .first_word(first_word),
		.post_second(post_second), .second_word(second_word),
		.send_taken(send_taken), .rx_byte(rx_byte), .rx_valid(rx_valid),
		.rx_count(rx_count), .frame_pending(frame_pending),
		.timed_out(timed_out), .host_seen(host_seen)
	);

	a_send_posts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_taken |-> post_first && frame_pending)
		else $error("send taken without post");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rx_valid |-> rx_byte == 8'd0)
		else $error("rx byte without pop");
	a_second: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && post_second |-> post_first)
		else $error("data1 write alone");
endmodule

[rtl/mabl_ram.sv]
// ----------------------------------------------------------------------------
// mabl_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mabl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/mabl_front.sv]
// ----------------------------------------------------------------------------
// mabl_front
// Input stage: accepts words and holds them in a two entry queue.
// ----------------------------------------------------------------------------
module mabl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mabl_pkg::item_t     in_item,
	output logic                q_valid,
	output mabl_pkg::item_t     q_item,
	input  logic                q_take
);
	import mabl_pkg::*;

	item_t    buf_q [2];
	logic     rd_q, wr_q;
	logic [1:0] cnt_q;
	logic     push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take};
		end
	end
endmodule

[rtl/mabl_back.sv]
// ----------------------------------------------------------------------------
// mabl_back
// Link engine: answer check, frame post, timeout and receive ring; each word is a
// ring read then an update, result held in an output register.
// ----------------------------------------------------------------------------
module mabl_back #(
	parameter int RX_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  mabl_pkg::item_t     q_item,
	output logic                q_take,
	input  logic [31:0]         polls_no_host,
	input  logic [31:0]         polls_host,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                post_first,
	output logic [31:0]         first_word,
	output logic                post_second,
	output logic [31:0]         second_word,
	output logic                send_taken,
	output logic [7:0]          rx_byte,
	output logic                rx_valid,
	output logic [4:0]          rx_count,
	output logic                frame_pending,
	output logic                timed_out,
	output logic                host_seen
);
	import mabl_pkg::*;

	localparam int AW = $clog2(RX_DEPTH);

	logic [AW-1:0] head_q, tail_q;
	logic seq_q, lhb_q, posted_q, sync_q, host_q, latch_q, long_q, wrote_q, started_q;
	logic [31:0] flo_q, fhi_q, budget_q;
	logic busy_q;
	logic [7:0] rdata;

	logic we0, we1;
	logic [AW-1:0] wa0, wa1, wa;
	logic [7:0] wd0, wd1, wd;
	logic wsel_q;
	logic [7:0] wd1_q;
	logic [AW-1:0] wa1_q;

	mabl_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_ring (
		.clk(clk), .we(we0 || wsel_q), .waddr(wa), .wdata(wd),
		.raddr(head_q), .rdata(rdata)
	);
	assign wa = wsel_q ? wa1_q : wa0;
	assign wd = wsel_q ? wd1_q : wd0;

	function automatic logic [AW-1:0] fill(input logic [AW-1:0] t, input logic [AW-1:0] h);
		return (t >= h) ? AW'(t - h) : AW'(32'(RX_DEPTH) - 32'(h) + 32'(t));
	endfunction

	logic [AW-1:0] count;
	assign count = fill(tail_q, head_q);

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
		return (32'(p) + 1 >= RX_DEPTH) ? '0 : AW'(32'(p) + 1);
	endfunction

	// next state
	logic n_seq, n_lhb, n_posted, n_sync, n_host, n_latch, n_long, n_wrote, n_started;
	logic [31:0] n_flo, n_fhi, n_budget, n_w0, n_w1, reload;
	logic [AW-1:0] n_head, n_tail;
	logic o_pf, o_ps, o_tk, o_rv;
	logic [7:0] o_rb;
	logic done;
	logic [7:0] a0;
	logic [2:0] m, n;
	logic [63:0] fb;
	logic [7:0] crc;
	logic [AW-1:0] cnt_after;

	logic step;
	assign step = busy_q && (!out_valid || !out_stall);
	assign q_take = step;

	always_comb begin
		logic [31:0] w;
		logic ok, h;
		logic [7:0] ac;
		logic [63:0] pb;
		logic post_req;
		logic [2:0] pn;
		logic [47:0] pp;
		w = q_item.mailbox_word;
		n_seq = seq_q; n_lhb = lhb_q; n_posted = posted_q; n_sync = sync_q;
		n_host = host_q; n_latch = latch_q; n_long = long_q; n_wrote = wrote_q;
		n_started = started_q; n_flo = flo_q; n_fhi = fhi_q; n_budget = budget_q;
		n_head = head_q; n_tail = tail_q;
		o_pf = 1'b0; o_ps = 1'b0; o_tk = 1'b0; o_rv = 1'b0; o_rb = 8'd0;
		n_w0 = 32'd0; n_w1 = 32'd0; reload = 32'd0;
		we0 = 1'b0; wa0 = tail_q; wd0 = w[15:8];
		we1 = 1'b0; wa1 = inc(tail_q); wd1 = w[23:16];
		done = 1'b1; a0 = w[7:0]; m = a0[2:0]; n = 3'd0;
		fb = 64'd0; crc = 8'd0; cnt_after = '0;
		post_req = 1'b0; pn = 3'd0; pp = q_item.payload;
		ac = 8'd0; ok = 1'b0; h = 1'b0; pb = 64'd0;
		if (q_item.op == OP_START) begin
			o_pf = 1'b1;
			n_head = '0; n_tail = '0; n_seq = 1'b0; n_lhb = 1'b1; n_posted = 1'b0;
			n_sync = 1'b1; n_host = 1'b0; n_latch = 1'b0; n_long = 1'b0;
			n_wrote = 1'b0; n_started = 1'b1;
		end else if (started_q && q_item.op <= OP_POP) begin
			// answer check
			if (posted_q && (q_item.op != OP_SEND)) begin
				if (w[7]) begin
					done = 1'b0;
				end else begin
					ac = crc8_bytes({32'd0, w}, {1'b0, m} + 4'd1);
					ok = (m <= 3'd2) && (ac == w[8*(m+3'd1) +: 8]) && (w[5] == seq_q);
					if (!ok) begin
						done = 1'b0;
						o_pf = 1'b1; n_w0 = flo_q; o_ps = long_q;
						n_w1 = long_q ? fhi_q : 32'd0;
					end else begin
						n_posted = 1'b0; n_sync = 1'b0; n_host = 1'b1; n_latch = 1'b0;
						n_seq = ~seq_q;
						h = w[4];
						if (m != 3'd0 && h != lhb_q &&
							32'(RX_DEPTH - 1) - 32'(count) >= 32'(m)) begin
							we0 = 1'b1;
							we1 = (m == 3'd2);
							n_tail = (m == 3'd2) ? inc(inc(tail_q)) : inc(tail_q);
							n_lhb = h;
						end
					end
				end
			end
			case (q_item.op)
				OP_OBSERVE: begin
					if (posted_q && !done && !latch_q) begin
						if (budget_q <= 32'd1) begin
							n_budget = 32'd0;
							n_latch = 1'b1; n_host = 1'b0;
							pb = {fhi_q, flo_q};
							pb[6] = 1'b1;
							n = (pb[2:0] > 3'd6) ? 3'd6 : pb[2:0];
							crc = crc8_bytes(pb, {1'b0, n} + 4'd1);
							pb[8*({1'b0, n}+4'd1) +: 8] = crc;
							n_flo = pb[31:0]; n_fhi = pb[63:32];
							o_pf = 1'b1; n_w0 = pb[31:0]; o_ps = long_q;
							n_w1 = long_q ? pb[63:32] : 32'd0;
						end else begin
							n_budget = budget_q - 32'd1;
						end
					end
				end
				OP_SEND: begin
					if (!posted_q && q_item.payload_len != 3'd0) begin
						post_req = 1'b1;
						pn = (q_item.payload_len > 3'd6) ? 3'd6 : q_item.payload_len;
						n_wrote = 1'b1; o_tk = 1'b1;
					end
				end
				OP_PROBE: begin
					if (!n_posted && !n_latch) begin
						if (!wrote_q) begin
							post_req = 1'b1; pn = 3'd0; pp = 48'd0;
						end
						n_wrote = 1'b0;
					end
				end
				OP_POP: begin
					if (fill(n_tail, head_q) != '0) begin
						o_rv = 1'b1; o_rb = (count == '0) ? wd0 : rdata;
						n_head = inc(head_q);
					end
				end
				default: ;
			endcase
			if (post_req) begin
				fb = 64'd0;
				fb[7:0] = {1'b1, 1'b0, n_seq, n_lhb, n_sync, pn};
				for (int i = 0; i < 6; i++) begin
					if (3'(i) < pn) fb[8*(i+1) +: 8] = pp[8*i +: 8];
				end
				crc = crc8_bytes(fb, {1'b0, pn} + 4'd1);
				fb[8*({1'b0, pn}+4'd1) +: 8] = crc;
				n_long = (pn >= 3'd3);
				n_flo = fb[31:0]; n_fhi = fb[63:32];
				reload = n_host ? ((polls_host == 32'd0) ? 32'd1 : polls_host)
					: ((polls_no_host == 32'd0) ? 32'd1 : polls_no_host);
				n_budget = reload; n_posted = 1'b1;
				o_pf = 1'b1; n_w0 = fb[31:0]; o_ps = n_long;
				n_w1 = n_long ? fb[63:32] : 32'd0;
			end
		end
		cnt_after = fill(n_tail, n_head);
	end

	always_ff @(posedge clk) begin
		if (step) begin
			first_word  <= n_w0;
			second_word <= n_w1;
			rx_byte     <= o_rb;
			flo_q <= n_flo; fhi_q <= n_fhi; budget_q <= n_budget;
			wd1_q <= wd1; wa1_q <= wa1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; out_valid <= 1'b0; wsel_q <= 1'b0;
			head_q <= '0; tail_q <= '0; seq_q <= 1'b0; lhb_q <= 1'b1;
			posted_q <= 1'b0; sync_q <= 1'b1; host_q <= 1'b0; latch_q <= 1'b0;
			long_q <= 1'b0; wrote_q <= 1'b0; started_q <= 1'b0;
			post_first <= 1'b0; post_second <= 1'b0; send_taken <= 1'b0;
			rx_valid <= 1'b0; rx_count <= 5'd0; frame_pending <= 1'b0;
			timed_out <= 1'b0; host_seen <= 1'b0;
		end else begin
			wsel_q <= step && we1;
			if (out_valid && !out_stall && !step) out_valid <= 1'b0;
			if (step) begin
				busy_q <= 1'b0;
				out_valid <= 1'b1;
				head_q <= n_head; tail_q <= n_tail; seq_q <= n_seq; lhb_q <= n_lhb;
				posted_q <= n_posted; sync_q <= n_sync; host_q <= n_host;
				latch_q <= n_latch; long_q <= n_long; wrote_q <= n_wrote;
				started_q <= n_started;
				post_first <= o_pf; post_second <= o_ps; send_taken <= o_tk;
				rx_valid <= o_rv; rx_count <= 5'(cnt_after);
				frame_pending <= n_posted; timed_out <= n_latch; host_seen <= n_host;
			end else if (!busy_q && q_valid && !wsel_q) begin
				busy_q <= 1'b1;
			end
		end
	end
endmodule

[verif/mailbox_alternating_bit_link_top_test.sv]
// ----------------------------------------------------------------------------
// mailbox_alternating_bit_link_top_test
// Drives op words into the mailbox link through a valid/stall channel with
// random idling and back-pressure. A local copy of the link state predicts
// every result word, which is checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
module mailbox_alternating_bit_link_top_test;
	import mabl_pkg::*;

	localparam logic [2:0] OP_RSVD_LO = 3'd5;
	localparam logic [2:0] OP_RSVD_HI = 3'd7;
	localparam int RING_DEPTH = 32;

	typedef struct {
		logic        pf;
		logic [31:0] w0;
		logic        ps;
		logic [31:0] w1;
		logic        taken;
		logic [7:0]  rb;
		logic        rv;
		logic [4:0]  cnt;
		logic        pend;
		logic        to;
		logic        hs;
	} link_res_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  op;
	logic [31:0] mailbox_word;
	logic [47:0] payload;
	logic [2:0]  payload_len;
	logic        out_valid;
	logic        out_stall;
	logic        post_first;
	logic [31:0] first_word;
	logic        post_second;
	logic [31:0] second_word;
	logic        send_taken;
	logic [7:0]  rx_byte;
	logic        rx_valid;
	logic [4:0]  rx_count;
	logic        frame_pending;
	logic        timed_out;
	logic        host_seen;

	mailbox_alternating_bit_link_top u_dut (.*);

	// link state copy
	logic [7:0]  m_ring [RING_DEPTH];
	int          m_head, m_tail;
	logic        m_seq, m_last_host, m_posted, m_sync, m_host, m_latch, m_long;
	logic        m_wrote, m_started;
	logic [31:0] m_lo, m_hi, m_budget, m_wait_no_host, m_wait_host;
	link_res_t   m_res;

	link_res_t   expected_words [$];
	int          mismatches;
	int          send_idle_pct;
	int          stall_pct;
	int          hold_cycles;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [7:0] crc8_of(input logic [7:0] b [8], input int n);
		logic [7:0] c;
		c = 8'hff;
		for (int i = 0; i < n; i++) begin
			c = c ^ b[i];
			for (int k = 0; k < 8; k++)
				c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic int ring_fill();
		return m_tail >= m_head ? m_tail - m_head : RING_DEPTH - m_head + m_tail;
	endfunction

	function automatic void emit_words(input logic [31:0] w0, input logic [31:0] w1,
			input logic two);
		m_res.pf = 1'b1;
		m_res.w0 = w0;
		m_res.ps = two;
		m_res.w1 = two ? w1 : 32'd0;
	endfunction

	function automatic void post_frame(input logic [47:0] pl, input int n);
		logic [7:0] b [8];
		for (int i = 0; i < 8; i++)
			b[i] = 8'd0;
		b[0] = 8'h80 | (m_seq ? 8'h20 : 8'h00) | (m_last_host ? 8'h10 : 8'h00) |
			(m_sync ? 8'h08 : 8'h00) | 8'(n);
		for (int i = 0; i < n; i++)
			b[1 + i] = pl[8*i +: 8];
		b[1 + n] = crc8_of(b, 1 + n);
		m_long = n >= 3;
		m_lo = {b[3], b[2], b[1], b[0]};
		m_hi = {b[7], b[6], b[5], b[4]};
		m_budget = m_host ? m_wait_host : m_wait_no_host;
		if (m_budget == 32'd0)
			m_budget = 32'd1;
		m_posted = 1'b1;
		emit_words(m_lo, m_hi, m_long);
	endfunction

	function automatic logic answer_done(input logic [31:0] w);
		logic [7:0] a [8];
		int m;
		logic ok;
		if (!m_posted)
			return 1'b1;
		if (w[7])
			return 1'b0;
		for (int i = 0; i < 8; i++)
			a[i] = i < 4 ? w[8*i +: 8] : 8'd0;
		m = a[0][2:0];
		ok = m <= 2 && crc8_of(a, 1 + m) == a[1 + m] && a[0][5] == m_seq;
		if (!ok) begin
			emit_words(m_lo, m_hi, m_long);
			return 1'b0;
		end
		m_posted = 1'b0;
		m_sync = 1'b0;
		m_host = 1'b1;
		m_latch = 1'b0;
		m_seq = ~m_seq;
		if (m != 0 && a[0][4] != m_last_host && (RING_DEPTH - 1) - ring_fill() >= m) begin
			for (int i = 0; i < m; i++) begin
				m_ring[m_tail] = a[1 + i];
				m_tail = m_tail + 1 >= RING_DEPTH ? 0 : m_tail + 1;
			end
			m_last_host = a[0][4];
		end
		return 1'b1;
	endfunction

	function automatic void frame_timeout();
		logic [7:0] b [8];
		int n;
		m_latch = 1'b1;
		m_host = 1'b0;
		for (int i = 0; i < 4; i++) begin
			b[i] = m_lo[8*i +: 8];
			b[4 + i] = m_hi[8*i +: 8];
		end
		b[0] = b[0] | 8'h40;
		n = b[0][2:0];
		if (n > 6)
			n = 6;
		b[1 + n] = crc8_of(b, 1 + n);
		m_lo = {b[3], b[2], b[1], b[0]};
		m_hi = {b[7], b[6], b[5], b[4]};
		emit_words(m_lo, m_hi, m_long);
	endfunction

	function automatic void link_reset();
		m_head = 0;
		m_tail = 0;
		m_seq = 1'b0;
		m_last_host = 1'b1;
		m_posted = 1'b0;
		m_sync = 1'b1;
		m_host = 1'b0;
		m_latch = 1'b0;
		m_long = 1'b0;
		m_wrote = 1'b0;
	endfunction

	function automatic link_res_t predict_link(input logic [2:0] o, input logic [31:0] mw,
			input logic [47:0] pl, input logic [2:0] ln);
		logic done;
		m_res = '{default: '0};
		if (o == OP_START) begin
			emit_words(32'd0, 32'd0, 1'b0);
			link_reset();
			m_started = 1'b1;
		end else if (m_started && o <= OP_POP) begin
			case (o)
				OP_OBSERVE: begin
					if (m_posted) begin
						done = answer_done(mw);
						if (!done && !m_latch) begin
							if (m_budget <= 32'd1) begin
								m_budget = 32'd0;
								frame_timeout();
							end else begin
								m_budget = m_budget - 32'd1;
							end
						end
					end
				end
				OP_SEND: begin
					if (!m_posted && ln != 3'd0) begin
						post_frame(pl, ln > 3'd6 ? 6 : int'(ln));
						m_wrote = 1'b1;
						m_res.taken = 1'b1;
					end
				end
				OP_PROBE: begin
					done = answer_done(mw);
					if (!m_posted && !m_latch) begin
						if (!m_wrote)
							post_frame(48'd0, 0);
						m_wrote = 1'b0;
					end
				end
				default: begin
					done = answer_done(mw);
					if (ring_fill() != 0) begin
						m_res.rb = m_ring[m_head];
						m_res.rv = 1'b1;
						m_head = m_head + 1 >= RING_DEPTH ? 0 : m_head + 1;
					end
				end
			endcase
		end
		m_res.cnt = 5'(ring_fill());
		m_res.pend = m_posted;
		m_res.to = m_latch;
		m_res.hs = m_host;
		return m_res;
	endfunction

	// host answer word; good ones carry the current sequence bit
	function automatic logic [31:0] host_answer(input logic right_seq, input logic bad_crc);
		logic [7:0] a [8];
		int m;
		a[0] = 8'($urandom) & 8'h5f;
		m = $urandom_range(0, 2);
		a[0][2:0] = 3'(m);
		a[0][5] = right_seq ? m_seq : ~m_seq;
		for (int i = 1; i < 8; i++)
			a[i] = 8'($urandom);
		a[1 + m] = crc8_of(a, 1 + m) ^ (bad_crc ? 8'(1 << $urandom_range(0, 7)) : 8'd0);
		return {a[3], a[2], a[1], a[0]};
	endfunction

	task automatic push_word(input logic [2:0] o, input logic [31:0] mw,
			input logic [47:0] pl, input logic [2:0] ln);
		op = o;
		mailbox_word = mw;
		payload = pl;
		payload_len = ln;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		expected_words.push_back(predict_link(o, mw, pl, ln));
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		drain();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_NO_HOST)
			m_wait_no_host = val;
		else
			m_wait_host = val;
	endtask

	task automatic random_word();
		int r;
		r = $urandom_range(99);
		if (r < 28)
			push_word(OP_OBSERVE, host_answer(1'b1, 1'b0), '0, '0);
		else if (r < 34)
			push_word(OP_OBSERVE, host_answer(1'b0, 1'b0), '0, '0);
		else if (r < 38)
			push_word(OP_OBSERVE, host_answer(1'b1, 1'b1), '0, '0);
		else if (r < 46)
			push_word(OP_OBSERVE, $urandom, '0, '0);
		else if (r < 66)
			push_word(OP_SEND, $urandom, {16'($urandom), 32'($urandom)},
				3'($urandom_range(0, 7)));
		else if (r < 76)
			push_word(OP_PROBE, $urandom_range(1) ? host_answer(1'b1, 1'b0) : $urandom,
				'0, '0);
		else if (r < 95)
			push_word(OP_POP, $urandom_range(1) ? host_answer(1'b1, 1'b0) : $urandom, '0, '0);
		else if (r < 97)
			push_word(OP_START, $urandom, '0, '0);
		else
			push_word(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), $urandom,
				{16'($urandom), 32'($urandom)}, 3'($urandom));
	endtask

	task automatic test_directed();
		write_reg(REG_NO_HOST, 32'd3);
		write_reg(REG_HOST, 32'd2);
		push_word(OP_OBSERVE, 32'd0, '0, '0);
		push_word(OP_SEND, '0, '1, 3'd6);
		push_word(OP_PROBE, '0, '0, '0);
		push_word(OP_POP, '0, '0, '0);
		push_word(OP_START, '1, '1, '1);
		push_word(OP_SEND, '0, '1, 3'd0);
		push_word(OP_SEND, '0, '1, 3'd7);
		push_word(OP_OBSERVE, 32'hffff_ffff, '0, '0);
		push_word(OP_OBSERVE, host_answer(1'b1, 1'b1), '0, '0);
		push_word(OP_OBSERVE, host_answer(1'b1, 1'b0), '0, '0);
		push_word(OP_PROBE, '0, '0, '0);
		push_word(OP_PROBE, '0, '0, '0);
		for (int i = 0; i < 4; i++)
			push_word(OP_OBSERVE, host_answer(1'b0, 1'b0), '0, '0);
		push_word(OP_PROBE, '0, '0, '0);
		push_word(OP_SEND, '0, 48'h0102_0304_0506, 3'd3);
		push_word(OP_POP, host_answer(1'b1, 1'b0), '0, '0);
		push_word(OP_POP, '0, '0, '0);
		push_word(OP_POP, '0, '0, '0);
		push_word(OP_SEND, '0, 48'h0, 3'd2);
		push_word(OP_OBSERVE, 32'h0000_0000, '0, '0);
		push_word(OP_RSVD_LO, '1, '1, '1);
		push_word(OP_RSVD_HI, '0, '0, '0);
		push_word(OP_START, '0, '0, '0);
	endtask

	task automatic test_random(input int n, input logic [31:0] no_host, input logic [31:0] host,
			input int idle, input int stall);
		write_reg(REG_NO_HOST, no_host);
		write_reg(REG_HOST, host);
		send_idle_pct = idle;
		stall_pct = stall;
		push_word(OP_START, '0, '0, '0);
		for (int i = 0; i < n; i++)
			random_word();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 300;
		for (int i = 0; i < 40; i++)
			random_word();
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 20; i++)
			random_word();
		drain();
		for (int i = 0; i < 20; i++)
			random_word();
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= $urandom_range(99) < stall_pct;
		end
	end

	always @(posedge clk) begin
		link_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word");
			end else begin
				e = expected_words.pop_front();
				if (post_first !== e.pf || first_word !== e.w0 || post_second !== e.ps ||
						second_word !== e.w1 || send_taken !== e.taken || rx_byte !== e.rb ||
						rx_valid !== e.rv || rx_count !== e.cnt || frame_pending !== e.pend ||
						timed_out !== e.to || host_seen !== e.hs) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %0b %h %0b %h %0b %h %0b %0d %0b %0b %0b",
							e.pf, e.w0, e.ps, e.w1, e.taken, e.rb, e.rv, e.cnt, e.pend,
							e.to, e.hs, "\n         got %0b %h %0b %h %0b %h %0b %0d %0b %0b %0b",
							post_first, first_word, post_second, second_word, send_taken,
							rx_byte, rx_valid, rx_count, frame_pending, timed_out, host_seen);
				end
			end
		end
	end

	initial begin
		#40_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = OP_OBSERVE;
		mailbox_word = '0;
		payload = '0;
		payload_len = '0;
		out_stall = 1'b0;
		mismatches = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		m_started = 1'b0;
		m_lo = '0;
		m_hi = '0;
		m_budget = '0;
		m_wait_no_host = 32'd6000;
		m_wait_host = 32'd60000;
		link_reset();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(500, 32'd4, 32'd6, 0, 0);
		test_random(500, 32'd1, 32'd3, 78, 0);
		test_random(500, 32'd0, 32'hffff_ffff, 0, 78);
		test_random(400, 32'hffff_ffff, 32'd1, 27, 27);
		test_backpressure();
		test_drain_pause();
		drain();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
